// File: design/tmcg_pkg.sv
// Package for the luma tone map and colour gain core.
// Holds widths, register indexes, reset values and curve constants; no dependencies.
`default_nettype none
package tmcg_pkg;
   localparam int PixW   = 8;
   localparam int GainW  = 12;
   localparam int OffW   = 16;
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = 16;
   localparam int LumaW  = PixW + GainW;
   localparam int LqNumW = LumaW + 16;
   localparam int LqDenW = LumaW + 5;
   localparam int LqW    = 16;
   localparam int BaseW  = 22;
   localparam int ProdW  = 41;
   localparam int HiW    = 26;
   localparam int NumChan = 3;

   localparam logic [15:0] CurveScale = 16'd65280;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_TONE_MODE   = 3'd0,
      CSR_LUMA_GAIN   = 3'd1,
      CSR_TONE_OFFSET = 3'd2,
      CSR_BLUE_GAIN   = 3'd3,
      CSR_GREEN_GAIN  = 3'd4,
      CSR_RED_GAIN    = 3'd5
   } csr_index_type;

   localparam logic             ResetToneMode   = 1'b0;
   localparam logic [GainW-1:0] ResetGain       = 12'd256;
   localparam logic [OffW-1:0]  ResetToneOffset = 16'd255;
endpackage
`default_nettype wire

// File: design/tmcg_if.sv
// Stream interfaces for the pixel requests and the corrected pixel responses.
// Depends on tmcg_pkg for field widths.
`default_nettype none
interface tmcg_req_if;
   logic                      valid;
   logic                      ready;
   logic [tmcg_pkg::PixW-1:0] luma_in;
   logic [tmcg_pkg::PixW-1:0] blue_in;
   logic [tmcg_pkg::PixW-1:0] green_in;
   logic [tmcg_pkg::PixW-1:0] red_in;
   logic                      frame_end_in;
   modport source (output valid, luma_in, blue_in, green_in, red_in, frame_end_in,
                   input ready);
   modport sink (input valid, luma_in, blue_in, green_in, red_in, frame_end_in,
                 output ready);
endinterface

interface tmcg_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [tmcg_pkg::PixW-1:0] blue_out;
   logic [tmcg_pkg::PixW-1:0] green_out;
   logic [tmcg_pkg::PixW-1:0] red_out;
   logic                      frame_end_out;
   modport source (output valid, blue_out, green_out, red_out, frame_end_out,
                   input ready);
   modport sink (input valid, blue_out, green_out, red_out, frame_end_out,
                 output ready);
endinterface
`default_nettype wire

// File: design/luma_tone_map_color_gain_core.sv
// Top level of the luma tone map and colour gain core.
// Depends on tmcg_pkg, the stream interfaces in tmcg_if and the divider tmcg_div.
//
// The core takes one pixel beat per clock while the response side is not stalled and
// returns one corrected pixel beat per pixel, in order. The pipeline holds the two
// pipelined dividers, seventeen register stages for the photographic curve and nine for
// the colour ratio, plus the gain, base, multiply and output registers. When the response
// beat is held, the whole pipeline holds and request ready drops. The user must write
// registers through the csr port while no pixel is in flight; not enforced by the core.
`default_nettype none
module luma_tone_map_color_gain_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   tmcg_req_if.sink                             req_bus,
   tmcg_rsp_if.source                           rsp_bus,
   input  wire logic                            csr_we,
   input  wire logic [tmcg_pkg::CsrIdxW-1:0]    csr_index,
   input  wire logic [tmcg_pkg::CsrDataW-1:0]   csr_wdata
);
   localparam int PW = tmcg_pkg::PixW;
   localparam int GW = tmcg_pkg::GainW;
   localparam int NC = tmcg_pkg::NumChan;

   logic                         tone_mode_ff;
   logic [GW-1:0]                luma_gain_ff;
   logic [tmcg_pkg::OffW-1:0]    tone_offset_ff;
   logic [GW-1:0]                chan_gain_ff [0:NC-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_mode_ff   <= tmcg_pkg::ResetToneMode;
         luma_gain_ff   <= tmcg_pkg::ResetGain;
         tone_offset_ff <= tmcg_pkg::ResetToneOffset;
         for (int c = 0; c < NC; c++) chan_gain_ff[c] <= tmcg_pkg::ResetGain;
      end else if (csr_we) begin
         case (tmcg_pkg::csr_index_type'(csr_index))
            tmcg_pkg::CSR_TONE_MODE:   tone_mode_ff   <= csr_wdata[0];
            tmcg_pkg::CSR_LUMA_GAIN:   luma_gain_ff   <= csr_wdata[GW-1:0];
            tmcg_pkg::CSR_TONE_OFFSET: tone_offset_ff <= csr_wdata;
            tmcg_pkg::CSR_BLUE_GAIN:   chan_gain_ff[0] <= csr_wdata[GW-1:0];
            tmcg_pkg::CSR_GREEN_GAIN:  chan_gain_ff[1] <= csr_wdata[GW-1:0];
            tmcg_pkg::CSR_RED_GAIN:    chan_gain_ff[2] <= csr_wdata[GW-1:0];
            default: ;
         endcase
      end
   end

   logic en;
   logic rsp_valid_ff;
   assign en = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = en;

   // Stage A: gained luma.
   logic                            vld_a_ff;
   logic [tmcg_pkg::LumaW-1:0]      l8_a_ff;
   logic [PW-1:0]                   y_a_ff;
   logic [PW-1:0]                   c_a_ff [0:NC-1];
   logic                            fe_a_ff;

   always_ff @(posedge clock) begin
      if (reset) vld_a_ff <= 1'b0;
      else if (en) vld_a_ff <= req_bus.valid && req_bus.ready;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l8_a_ff   <= tmcg_pkg::LumaW'(req_bus.luma_in) * tmcg_pkg::LumaW'(luma_gain_ff);
         y_a_ff    <= req_bus.luma_in;
         c_a_ff[0] <= req_bus.blue_in;
         c_a_ff[1] <= req_bus.green_in;
         c_a_ff[2] <= req_bus.red_in;
         fe_a_ff   <= req_bus.frame_end_in;
      end
   end

   localparam int SideW = 1 + 4 * PW + tmcg_pkg::LumaW;
   logic [tmcg_pkg::LqNumW-1:0] lq_num;
   logic [tmcg_pkg::LqDenW-1:0] lq_den_raw;
   logic [tmcg_pkg::LqDenW-1:0] lq_den;
   logic                        vld_d1;
   logic [tmcg_pkg::LqW-1:0]    lq_quo;
   logic [SideW-1:0]            side_d1;

   assign lq_num     = tmcg_pkg::LqNumW'(l8_a_ff) * tmcg_pkg::LqNumW'(tmcg_pkg::CurveScale);
   assign lq_den_raw = tmcg_pkg::LqDenW'(l8_a_ff) + {1'b0, tone_offset_ff, 8'd0};
   assign lq_den     = (lq_den_raw == '0) ? tmcg_pkg::LqDenW'(1) : lq_den_raw;

   tmcg_div #(
      .NW(tmcg_pkg::LqNumW), .DW(tmcg_pkg::LqDenW), .QW(tmcg_pkg::LqW), .SW(SideW)
   ) u_lq_div (
      .clock(clock), .reset(reset), .en(en), .in_valid(vld_a_ff),
      .num(lq_num), .den(lq_den),
      .side({fe_a_ff, y_a_ff, c_a_ff[0], c_a_ff[1], c_a_ff[2], l8_a_ff}),
      .out_valid(vld_d1), .quo(lq_quo), .out_side(side_d1)
   );

   logic [tmcg_pkg::LumaW-1:0] l8_d1;
   logic [PW-1:0]              y_d1;
   logic [PW-1:0]              c_d1 [0:NC-1];
   logic                       fe_d1;
   assign {fe_d1, y_d1, c_d1[0], c_d1[1], c_d1[2], l8_d1} = side_d1;

   // Stage B: output luma and channel bases.
   logic                             vld_b_ff;
   logic [tmcg_pkg::LumaW-1:0]       lq_b_ff;
   logic [tmcg_pkg::BaseW-2:0]       base_b_ff [0:NC-1];
   logic [tmcg_pkg::BaseW-2:0]       base_in   [0:NC-1];
   logic signed [tmcg_pkg::BaseW-1:0] base_s   [0:NC-1];
   logic signed [PW:0]               diff      [0:NC-1];
   logic [PW-1:0]                    y_b_ff;
   logic                             fe_b_ff;

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         diff[c]   = $signed({1'b0, c_d1[c]}) - $signed({1'b0, y_d1});
         base_s[c] = $signed({{(tmcg_pkg::BaseW-GW){1'b0}}, chan_gain_ff[c]})
                   * $signed({{(tmcg_pkg::BaseW-PW-1){diff[c][PW]}}, diff[c]})
                   + $signed({{(tmcg_pkg::BaseW-PW-8){1'b0}}, y_d1, 8'd0});
         base_in[c] = (base_s[c] > 0) ? base_s[c][tmcg_pkg::BaseW-2:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_b_ff <= 1'b0;
      else if (en) vld_b_ff <= vld_d1;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lq_b_ff <= tone_mode_ff ? tmcg_pkg::LumaW'(lq_quo) : l8_d1;
         for (int c = 0; c < NC; c++) base_b_ff[c] <= base_in[c];
         y_b_ff  <= y_d1;
         fe_b_ff <= fe_d1;
      end
   end

   // Stage C: channel numerators.
   logic                       vld_c_ff;
   logic [tmcg_pkg::ProdW-1:0] prod_c_ff [0:NC-1];
   logic [PW-1:0]              y_c_ff;
   logic                       fe_c_ff;

   always_ff @(posedge clock) begin
      if (reset) vld_c_ff <= 1'b0;
      else if (en) vld_c_ff <= vld_b_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < NC; c++)
            prod_c_ff[c] <= tmcg_pkg::ProdW'(base_b_ff[c]) * tmcg_pkg::ProdW'(lq_b_ff);
         y_c_ff  <= y_b_ff;
         fe_c_ff <= fe_b_ff;
      end
   end

   // Rounding, saturation test and ratio division by luma.
   logic [tmcg_pkg::ProdW:0] rnd  [0:NC-1];
   logic [tmcg_pkg::HiW-1:0] hi   [0:NC-1];
   logic                     sat  [0:NC-1];
   logic [PW-1:0]            quo  [0:NC-1];
   logic [2:0]               flg  [0:NC-1];
   logic                     vld_ch [0:NC-1];
   logic [PW-1:0]            y_den;
   logic                     y_zero;

   assign y_zero = (y_c_ff == '0);
   assign y_den  = y_zero ? PW'(1) : y_c_ff;

   for (genvar c = 0; c < NC; c++) begin : g_chan
      assign rnd[c] = {1'b0, prod_c_ff[c]} + {{(tmcg_pkg::ProdW-PW-14){1'b0}}, y_c_ff, 15'd0};
      assign hi[c]  = rnd[c][tmcg_pkg::ProdW:16];
      assign sat[c] = hi[c] >= {{(tmcg_pkg::HiW-2*PW){1'b0}}, y_c_ff, 8'd0};

      tmcg_div #(.NW(tmcg_pkg::HiW), .DW(PW), .QW(PW), .SW(3)) u_ratio_div (
         .clock(clock), .reset(reset), .en(en), .in_valid(vld_c_ff),
         .num(sat[c] ? '0 : hi[c]), .den(y_den), .side({fe_c_ff, y_zero, sat[c]}),
         .out_valid(vld_ch[c]), .quo(quo[c]), .out_side(flg[c])
      );
   end

   // Output register.
   logic [PW-1:0] res_ff [0:NC-1];
   logic          fe_out_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (en) rsp_valid_ff <= vld_ch[0] && vld_ch[1] && vld_ch[2];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < NC; c++) begin
            if (flg[c][1]) res_ff[c] <= '0;
            else if (flg[c][0]) res_ff[c] <= '1;
            else res_ff[c] <= quo[c];
         end
         fe_out_ff <= flg[0][2] & flg[1][2] | flg[2][2] & flg[0][2];
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.blue_out      = res_ff[0];
   assign rsp_bus.green_out     = res_ff[1];
   assign rsp_bus.red_out       = res_ff[2];
   assign rsp_bus.frame_end_out = fe_out_ff;
endmodule
`default_nettype wire

// File: design/tmcg_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Generic widths; the caller guarantees the quotient fits in QW bits.
`default_nettype none
module tmcg_div #(
   parameter int NW = 36,
   parameter int DW = 25,
   parameter int QW = 16,
   parameter int SW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   input  wire logic [SW-1:0] side,
   output logic               out_valid,
   output logic [QW-1:0]      quo,
   output logic [SW-1:0]      out_side
);
   logic          vld_ff  [0:QW];
   logic [DW-1:0] rem_ff  [0:QW];
   logic [QW-1:0] lo_ff   [0:QW];
   logic [DW-1:0] den_ff  [0:QW];
   logic [SW-1:0] side_ff [0:QW];
   logic [DW:0]   trial   [0:QW-1];
   logic [DW-1:0] rem_in  [0:QW-1];
   logic [QW-1:0] lo_in   [0:QW-1];

   for (genvar i = 0; i < QW; i++) begin : g_step
      always_comb begin
         trial[i] = {rem_ff[i], lo_ff[i][QW-1]};
         if (trial[i] >= {1'b0, den_ff[i]}) begin
            rem_in[i] = DW'(trial[i] - {1'b0, den_ff[i]});
            lo_in[i]  = {lo_ff[i][QW-2:0], 1'b1};
         end else begin
            rem_in[i] = trial[i][DW-1:0];
            lo_in[i]  = {lo_ff[i][QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= QW; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int i = 0; i < QW; i++) vld_ff[i+1] <= vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= DW'(num >> QW);
         lo_ff[0]   <= num[QW-1:0];
         den_ff[0]  <= den;
         side_ff[0] <= side;
         for (int i = 0; i < QW; i++) begin
            rem_ff[i+1]  <= rem_in[i];
            lo_ff[i+1]   <= lo_in[i];
            den_ff[i+1]  <= den_ff[i];
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[QW];
   assign quo       = lo_ff[QW];
   assign out_side  = side_ff[QW];
endmodule
`default_nettype wire

// File: tb/sv/tmcg_checker.sv
// Checker for the luma tone map and colour gain core: predicts each corrected pixel.
// Depends on tmcg_pkg and the stream interfaces in tmcg_if; watches req, rsp and csr.
`default_nettype none
module tmcg_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   tmcg_req_if.sink                           req_mon,
   tmcg_rsp_if.sink                           rsp_mon,
   input  wire logic                          csr_we,
   input  wire logic [tmcg_pkg::CsrIdxW-1:0]  csr_index,
   input  wire logic [tmcg_pkg::CsrDataW-1:0] csr_wdata,
   output int                                 mismatch_count,
   output int                                 pending_pixels
);
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       frame_end;
   } pixel_out_type;

   logic             mode_ff;
   logic [11:0]      luma_gain_ff;
   logic [15:0]      offset_ff;
   logic [11:0]      chan_gain_ff [3];
   pixel_out_type    expected_pixels [$];

   function automatic logic [7:0] scale_channel(input logic [7:0] c, input logic [7:0] y,
                                                input logic [11:0] k,
                                                input longint unsigned lq);
      longint signed base;
      longint unsigned q;
      base = longint'(k) * (longint'(c) - longint'(y)) + 256 * longint'(y);
      if (base <= 0 || lq == 0) return 8'd0;
      q = (longint'(base) * lq + longint'(y) * 32768) / (longint'(y) * 65536);
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   function automatic pixel_out_type predict_pixel(input logic [7:0] y, input logic [7:0] b,
                                                   input logic [7:0] g, input logic [7:0] r,
                                                   input logic fe);
      longint unsigned gained;
      longint unsigned denom;
      longint unsigned lq;
      pixel_out_type p;
      gained = longint'(y) * longint'(luma_gain_ff);
      if (!mode_ff) begin
         lq = gained;
      end else begin
         denom = gained + longint'(offset_ff) * 256;
         lq = (denom == 0) ? 0 : (gained * 65280) / denom;
      end
      p.frame_end = fe;
      if (y == 0) begin
         p.blue = 0; p.green = 0; p.red = 0;
      end else begin
         p.blue  = scale_channel(b, y, chan_gain_ff[0], lq);
         p.green = scale_channel(g, y, chan_gain_ff[1], lq);
         p.red   = scale_channel(r, y, chan_gain_ff[2], lq);
      end
      return p;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   initial begin
      mismatch_count = 0;
      pending_pixels = 0;
   end

   always @(posedge clock) begin
      pixel_out_type want;
      if (reset) begin
         mode_ff <= tmcg_pkg::ResetToneMode;
         luma_gain_ff <= tmcg_pkg::ResetGain;
         offset_ff <= tmcg_pkg::ResetToneOffset;
         for (int i = 0; i < 3; i++) chan_gain_ff[i] <= tmcg_pkg::ResetGain;
         expected_pixels.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected beat", 0, 0);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_mon.blue_out !== want.blue)
                  report_mismatch("blue_out", rsp_mon.blue_out, want.blue);
               if (rsp_mon.green_out !== want.green)
                  report_mismatch("green_out", rsp_mon.green_out, want.green);
               if (rsp_mon.red_out !== want.red)
                  report_mismatch("red_out", rsp_mon.red_out, want.red);
               if (rsp_mon.frame_end_out !== want.frame_end)
                  report_mismatch("frame_end_out", rsp_mon.frame_end_out, want.frame_end);
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_pixels.push_back(predict_pixel(req_mon.luma_in, req_mon.blue_in,
               req_mon.green_in, req_mon.red_in, req_mon.frame_end_in));
         if (csr_we) begin
            case (csr_index)
               tmcg_pkg::CSR_TONE_MODE:   mode_ff <= csr_wdata[0];
               tmcg_pkg::CSR_LUMA_GAIN:   luma_gain_ff <= csr_wdata[11:0];
               tmcg_pkg::CSR_TONE_OFFSET: offset_ff <= csr_wdata;
               tmcg_pkg::CSR_BLUE_GAIN:   chan_gain_ff[0] <= csr_wdata[11:0];
               tmcg_pkg::CSR_GREEN_GAIN:  chan_gain_ff[1] <= csr_wdata[11:0];
               tmcg_pkg::CSR_RED_GAIN:    chan_gain_ff[2] <= csr_wdata[11:0];
               default: ;
            endcase
         end
      end
      pending_pixels = expected_pixels.size();
   end
endmodule
`default_nettype wire

// File: tb/sv/tb_luma_tone_map_color_gain_core.sv
// Top of the testbench for the luma tone map and colour gain core.
// Depends on tmcg_pkg, tmcg_if, the core and tmcg_checker; drives pixels and settings.
`default_nettype none
module tb_luma_tone_map_color_gain_core;
   localparam int SettleCycles = 40;
   localparam int StallLimit   = 3000;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [tmcg_pkg::CsrIdxW-1:0]  csr_index = '0;
   logic [tmcg_pkg::CsrDataW-1:0] csr_wdata = '0;
   int   mismatch_count;
   int   pending_pixels;
   int   idle_cycles = 0;
   bit   long_hold = 0;

   tmcg_req_if req_bus ();
   tmcg_rsp_if rsp_bus ();

   luma_tone_map_color_gain_core dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata));

   tmcg_checker pixel_checker (
      .clock(clock), .reset(reset), .req_mon(req_bus.sink), .rsp_mon(rsp_bus.sink),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count), .pending_pixels(pending_pixels));

   always #10 clock = ~clock;

   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   initial begin
      req_bus.valid = 1'b0;
      req_bus.luma_in = '0; req_bus.blue_in = '0; req_bus.green_in = '0;
      req_bus.red_in = '0;
      req_bus.frame_end_in = 1'b0;
      rsp_bus.ready = 1'b0;
   end

   // Response side: random stalls, with one long hold-off when asked.
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_bus.ready <= 0;
            repeat (200) @(negedge clock);
            long_hold = 0;
         end
         rsp_bus.ready <= 1;
         @(negedge clock);
         if ($urandom_range(0, 3) == 0) begin
            n = gap_length();
            if (n > 0) begin
               rsp_bus.ready <= 0;
               repeat (n) @(negedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= StallLimit);
      $display("** luma_tone_map_color_gain_core: FAILED **");
      $finish;
   end

   task automatic write_reg(input tmcg_pkg::csr_index_type idx, input int value);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= value[15:0];
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      req_bus.valid <= 0;
      @(negedge clock);
      while (pending_pixels != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic send_pixel(input int y, input int b, input int g, input int r,
                             input bit fe, input bit gaps);
      int n;
      if (gaps) begin
         n = gap_length();
         if (n > 0) begin
            req_bus.valid <= 0;
            repeat (n) @(negedge clock);
         end
      end
      req_bus.valid <= 1;
      req_bus.luma_in <= y[7:0]; req_bus.blue_in <= b[7:0]; req_bus.green_in <= g[7:0];
      req_bus.red_in <= r[7:0]; req_bus.frame_end_in <= fe;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic apply_setting(input int mode, input int lg, input int off,
                                input int bg, input int gg, input int rg);
      drain_pipeline();
      write_reg(tmcg_pkg::CSR_TONE_MODE, mode);
      write_reg(tmcg_pkg::CSR_LUMA_GAIN, lg);
      write_reg(tmcg_pkg::CSR_TONE_OFFSET, off);
      write_reg(tmcg_pkg::CSR_BLUE_GAIN, bg);
      write_reg(tmcg_pkg::CSR_GREEN_GAIN, gg);
      write_reg(tmcg_pkg::CSR_RED_GAIN, rg);
      csr_we <= 0;
   endtask

   task automatic random_pixels(input int count);
      int y;
      for (int i = 0; i < count; i++) begin
         y = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 255);
         send_pixel(y, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 7) == 0, 1);
      end
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed pixels at reset settings, then the extremes of both modes.
      send_pixel(0, 255, 255, 255, 1, 0);
      send_pixel(255, 255, 255, 255, 0, 0);
      send_pixel(1, 0, 255, 1, 1, 0);
      send_pixel(255, 0, 0, 0, 0, 0);
      send_pixel(128, 200, 64, 128, 0, 0);
      send_pixel(1, 255, 0, 1, 0, 0);
      apply_setting(0, 4095, 65535, 0, 4095, 256);
      send_pixel(255, 0, 255, 128, 1, 0);
      send_pixel(1, 255, 0, 1, 0, 0);
      send_pixel(200, 10, 250, 200, 0, 0);
      apply_setting(1, 0, 0, 4095, 0, 1);
      send_pixel(200, 10, 250, 200, 0, 0);
      send_pixel(0, 10, 20, 30, 1, 0);
      apply_setting(1, 4095, 1, 4095, 4095, 4095);
      send_pixel(255, 255, 0, 128, 0, 0);
      send_pixel(1, 0, 255, 1, 1, 0);
      send_pixel(17, 100, 3, 17, 0, 0);
      apply_setting(1, 256, 65535, 256, 256, 256);
      send_pixel(255, 255, 255, 255, 0, 0);
      send_pixel(3, 1, 254, 3, 1, 0);

      // Random phases, including a long response hold-off and a full drain.
      apply_setting(0, 256, 255, 256, 256, 256);
      long_hold = 1;
      random_pixels(250);
      drain_pipeline();
      random_pixels(100);
      apply_setting(1, 512, 255, 300, 200, 400);
      random_pixels(250);
      apply_setting(0, $urandom_range(0, 4095), $urandom_range(1, 65535),
                    $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095));
      random_pixels(200);
      apply_setting(1, $urandom_range(0, 4095), $urandom_range(1, 2000),
                    $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095));
      random_pixels(200);
      apply_setting(1, 4095, 65535, 128, 1024, 4095);
      random_pixels(200);

      drain_pipeline();
      if (mismatch_count == 0)
         $display("** luma_tone_map_color_gain_core: PASSED **");
      else
         $display("** luma_tone_map_color_gain_core: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire
